/* rtl/core/sktsig_pkg.sv */
package sktsig_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(GAIN_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << FRAC_BITS;

  localparam logic [31:0] PROCESS_NOISE_RESET     = 32'd655;
  localparam logic [31:0] MEASUREMENT_NOISE_RESET = 32'(1) << FRAC_BITS;
  localparam logic [31:0] VARIANCE_RESET          = 32'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_BUY  = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

endpackage

/* rtl/core/scalar_kalman_trade_signal_top.sv */
// Sequence: the predict runs at the accepting edge, then 1 setup, FRAC_BITS+1 radix-2 gain
// divide steps, FRAC_BITS+1 shift-add multiply steps and 1 update, which raises out_valid.
// One item is in flight at a time: in_ready is high only while idle, so a new item is
// taken after the previous one's serial divide, multiply and update. It is taken while the
// previous result still waits at the output; its update step holds until that result is taken.
// Reset (synchronous, active high): estimate 0, variance 1.0, flat position,
// noise registers to their defaults, no result pending.
module scalar_kalman_trade_signal_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [31:0]                        tick_price,
  input  logic [15:0]                        symbol_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [31:0]                        estimate_out,
  output logic [31:0]                        variance_out,
  output logic [1:0]                         order_signal,
  output logic [15:0]                        order_symbol,
  output logic                               holding,
  input  logic                               cfg_we,
  input  logic [sktsig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data
);
  import sktsig_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_MUL, S_DONE} state_t;

  state_t              state;
  logic [31:0]         process_noise;
  logic [31:0]         measurement_noise;
  logic [31:0]         estimate;
  logic [31:0]         variance;
  logic                held;
  logic [31:0]         price;
  logic [15:0]         sym;
  logic [32:0]         pred;
  logic [33:0]         cov;
  logic [33:0]         rem;
  logic [GAIN_W-1:0]   gain;
  logic [GAIN_W-1:0]   mg;
  logic [GAIN_W-1:0]   mv;
  logic [31:0]         diff;
  logic                up;
  logic [CNT_W-1:0]    cnt;
  logic [31+GAIN_W:0]  acc_e;
  logic [32+GAIN_W:0]  acc_v;

  logic [34:0]         rem_sh;
  logic                div_ge;
  logic [33:0]         rem_next;
  logic [GAIN_W-1:0]   gain_next;
  logic [GAIN_W-1:0]   gain_final;
  logic [31+GAIN_W:0]  acc_e_next;
  logic [32+GAIN_W:0]  acc_v_next;
  logic [31:0]         move;
  logic [31:0]         est_new;
  logic [33:0]         var_full;
  logic [31:0]         var_new;
  logic                buy;
  logic                sell;
  logic                publish;

  always_comb begin
    rem_sh     = {rem, (cnt == CNT_W'(FRAC_BITS)) ? pred[0] : 1'b0};
    div_ge     = rem_sh >= {1'b0, cov};
    rem_next   = div_ge ? 34'(rem_sh - {1'b0, cov}) : rem_sh[33:0];
    gain_next  = {gain[GAIN_W-2:0], div_ge};
    gain_final = (cov == '0) ? '0 : gain_next;
    acc_e_next = {acc_e[30+GAIN_W:0], 1'b0}
               + (mg[GAIN_W-1] ? {{GAIN_W{1'b0}}, diff} : '0);
    acc_v_next = {acc_v[31+GAIN_W:0], 1'b0}
               + (mv[GAIN_W-1] ? {{GAIN_W{1'b0}}, pred} : '0);
    move       = acc_e[FRAC_BITS+31:FRAC_BITS];
    est_new    = up ? estimate + move : estimate - move;
    var_full   = acc_v[FRAC_BITS+33:FRAC_BITS];
    var_new    = (var_full[33:32] != 2'b00) ? 32'hFFFF_FFFF : var_full[31:0];
    buy        = (est_new > price) && !held;
    sell       = (est_new < price) && held;
    publish    = (state == S_DONE) && (!out_valid || out_ready);
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
      estimate          <= '0;
      variance          <= VARIANCE_RESET;
      held              <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PROCESS_NOISE) begin
          process_noise <= cfg_data;
        end else if (cfg_index == CFG_MEASUREMENT_NOISE) begin
          measurement_noise <= cfg_data;
        end
      end
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            price <= tick_price;
            sym   <= symbol_id;
            pred  <= {1'b0, variance} + {1'b0, process_noise};
            state <= S_PREP;
          end
        end
        S_PREP: begin
          cov   <= {1'b0, pred} + {2'b00, measurement_noise};
          up    <= price >= estimate;
          diff  <= (price >= estimate) ? price - estimate : estimate - price;
          rem   <= {2'b00, pred[32:1]};
          gain  <= '0;
          cnt   <= CNT_W'(FRAC_BITS);
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_next;
          gain <= gain_next;
          if (cnt == '0) begin
            mg    <= gain_final;
            mv    <= ONE_Q - gain_final;
            acc_e <= '0;
            acc_v <= '0;
            cnt   <= CNT_W'(FRAC_BITS);
            state <= S_MUL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MUL: begin
          acc_e <= acc_e_next;
          acc_v <= acc_v_next;
          mg    <= {mg[GAIN_W-2:0], 1'b0};
          mv    <= {mv[GAIN_W-2:0], 1'b0};
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (publish) begin
            estimate     <= est_new;
            variance     <= var_new;
            estimate_out <= est_new;
            variance_out <= var_new;
            if (buy) begin
              held         <= 1'b1;
              holding      <= 1'b1;
              order_signal <= SIG_BUY;
              order_symbol <= sym;
            end else if (sell) begin
              held         <= 1'b0;
              holding      <= 1'b0;
              order_signal <= SIG_SELL;
              order_symbol <= sym;
            end else begin
              holding      <= held;
              order_signal <= SIG_NONE;
              order_symbol <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* test/tb_scalar_kalman_trade_signal_top.sv */
module tb_scalar_kalman_trade_signal_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sktsig_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;
  localparam longint PRICE_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] estimate;
    logic [31:0] variance;
    logic [1:0]  signal;
    logic [15:0] symbol;
    logic        held;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] tick_price = '0;
  logic [15:0] symbol_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] estimate_out;
  logic [31:0] variance_out;
  logic [1:0] order_signal;
  logic [15:0] order_symbol;
  logic holding;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] flt_est = '0;
  logic [31:0] flt_variance = VARIANCE_RESET;
  logic flt_held = 1'b0;
  logic [31:0] q_process = PROCESS_NOISE_RESET;
  logic [31:0] q_measure = MEASUREMENT_NOISE_RESET;

  tick_result_t expected_ticks[$];
  tick_result_t want;
  tick_result_t got;
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int stall_left = 0;
  int stall_roll;
  bit steady = 1'b0;

  scalar_kalman_trade_signal_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tick_price   (tick_price),
    .symbol_id    (symbol_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .estimate_out (estimate_out),
    .variance_out (variance_out),
    .order_signal (order_signal),
    .order_symbol (order_symbol),
    .holding      (holding),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Filter one tick and queue the result it must produce.
  task automatic filter_tick(input logic [31:0] price, input logic [15:0] sym);
    logic [32:0] pred;
    logic [33:0] cov;
    logic [63:0] gain;
    logic [63:0] move;
    logic [63:0] est_wide;
    logic [63:0] shrink;
    tick_result_t res;
    pred = {1'b0, flt_variance} + {1'b0, q_process};
    cov = {1'b0, pred} + {2'b0, q_measure};
    gain = '0;
    if (cov != '0) gain = ({31'b0, pred} << FRAC_BITS) / {30'b0, cov};
    if (gain > 64'(ONE_Q)) gain = 64'(ONE_Q);
    if (price >= flt_est) begin
      move = (gain * {32'b0, price - flt_est}) >> FRAC_BITS;
      est_wide = {32'b0, flt_est} + move;
    end else begin
      move = (gain * {32'b0, flt_est - price}) >> FRAC_BITS;
      est_wide = {32'b0, flt_est} - move;
    end
    if (est_wide > 64'(WORD_MAX)) est_wide = 64'(WORD_MAX);
    shrink = ((64'(ONE_Q) - gain) * {31'b0, pred}) >> FRAC_BITS;
    if (shrink > 64'(WORD_MAX)) shrink = 64'(WORD_MAX);
    flt_est = est_wide[31:0];
    flt_variance = shrink[31:0];
    res.signal = SIG_NONE;
    res.symbol = '0;
    if (flt_est > price && !flt_held) begin
      res.signal = SIG_BUY;
      res.symbol = sym;
      flt_held = 1'b1;
    end else if (flt_est < price && flt_held) begin
      res.signal = SIG_SELL;
      res.symbol = sym;
      flt_held = 1'b0;
    end
    res.estimate = flt_est;
    res.variance = flt_variance;
    res.held = flt_held;
    expected_ticks.push_back(res);
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 60);
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WORD_MAX;
      2, 3, 4, 5: return $urandom_range(0, 4096);
      6, 7: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_tick(input logic [31:0] price, input logic [15:0] sym);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_price <= price;
    symbol_id <= sym;
    do @(posedge clk); while (!in_ready);
    filter_tick(price, sym);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROCESS_NOISE:     q_process = value;
      CFG_MEASUREMENT_NOISE: q_measure = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold off until every queued result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic test_default_ticks();
    send_tick(32'h0000_0000, 16'h0000);
    send_tick(WORD_MAX, 16'hFFFF);
    send_tick(32'h0000_0000, 16'hAAAA);
    send_tick(WORD_MAX, 16'h5555);
    send_tick(32'h8000_0000, 16'h0001);
    send_tick(32'h7FFF_FFFF, 16'h8000);
  endtask

  task automatic test_zero_covariance();
    settle();
    write_reg(CFG_PROCESS_NOISE, '0);
    write_reg(CFG_MEASUREMENT_NOISE, '0);
    send_tick(32'h0064_0000, 16'h0100);
    send_tick(32'h0050_0000, 16'h0101);
    send_tick(32'h0070_0000, 16'h0102);
    send_tick(32'h0064_0000, 16'h0103);
  endtask

  task automatic test_noise_extremes();
    settle();
    write_reg(CFG_PROCESS_NOISE, WORD_MAX);
    write_reg(CFG_MEASUREMENT_NOISE, WORD_MAX);
    repeat (3) send_tick($urandom, 16'($urandom));
    settle();
    write_reg(CFG_MEASUREMENT_NOISE, '0);
    repeat (2) send_tick($urandom, 16'($urandom));
    settle();
    write_reg(CFG_PROCESS_NOISE, '0);
    write_reg(CFG_MEASUREMENT_NOISE, WORD_MAX);
    send_tick(32'h0000_0000, 16'h00FF);
    send_tick(WORD_MAX, 16'hFF00);
  endtask

  task automatic test_spare_index();
    settle();
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    write_reg(CFG_PROCESS_NOISE, PROCESS_NOISE_RESET);
    write_reg(CFG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RESET);
    send_tick(32'h1234_5678, 16'h1234);
    send_tick(32'h0000_0001, 16'hFEDC);
  endtask

  task automatic test_random_walk();
    longint level;
    int span;
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(CFG_PROCESS_NOISE, pick_noise());
      write_reg(CFG_MEASUREMENT_NOISE, pick_noise());
      steady = (ph == 2);
      level = longint'($urandom);
      span = $urandom_range(4, 24);
      for (int n = 0; n < 220; n++) begin
        case ($urandom_range(0, 19))
          0: level = longint'($urandom);
          1: level = 0;
          2: level = PRICE_MAX;
          default: level = level + longint'($urandom_range(0, 2 << span))
                           - longint'(1 << span);
        endcase
        if (level < 0) level = 0;
        if (level > PRICE_MAX) level = PRICE_MAX;
        send_tick(level[31:0], 16'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_random_noise();
    logic [31:0] price;
    longint near;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_reg(CFG_PROCESS_NOISE, pick_noise());
      write_reg(CFG_MEASUREMENT_NOISE, pick_noise());
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0: price = '0;
          1: price = WORD_MAX;
          2, 3: begin
            near = longint'(flt_est) + longint'($urandom_range(0, 8)) - 4;
            if (near < 0) near = 0;
            if (near > PRICE_MAX) near = PRICE_MAX;
            price = near[31:0];
          end
          default: price = $urandom;
        endcase
        send_tick(price, 16'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{estimate_out, variance_out, order_signal, order_symbol, holding};
        results_seen++;
        if (expected_ticks.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result %0d: est %h var %h sig %0d sym %h hold %b",
                     results_seen, got.estimate, got.variance, got.signal,
                     got.symbol, got.held);
        end else begin
          want = expected_ticks.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on result %0d", results_seen);
              $display("  expected est %h var %h sig %0d sym %h hold %b",
                       want.estimate, want.variance, want.signal, want.symbol, want.held);
              $display("  actual   est %h var %h sig %0d sym %h hold %b",
                       got.estimate, got.variance, got.signal, got.symbol, got.held);
            end
          end
        end
      end
      if (steady) begin
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 60) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left <= (stall_roll < 92) ? $urandom_range(0, 3) : $urandom_range(4, 60);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_ticks();
    test_zero_covariance();
    test_noise_extremes();
    test_spare_index();
    test_random_walk();
    test_random_noise();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* scalar_kalman_trade_signal_top.f */
rtl/core/sktsig_pkg.sv
rtl/core/scalar_kalman_trade_signal_top.sv
test/tb_scalar_kalman_trade_signal_top.sv
